// ===== hdl/grid_best_first_path_search_macros.svh =====
// Assertion macros shared by the search block.
`ifndef GRID_BEST_FIRST_PATH_SEARCH_MACROS_SVH
`define GRID_BEST_FIRST_PATH_SEARCH_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define GBFS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next.
`define GBFS_CHECK_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ===== hdl/gbfs_pkg.sv =====
// Types, constants and helper functions of the grid search block.
package gbfs_pkg;

  localparam int P_MAX_STEPS    = 64;
  localparam int P_GRID_SIDE    = 256;
  localparam int P_MAX_PATH_OUT = 64;

  localparam int COORD_W = 8;
  localparam int ALT_W   = 16;
  localparam int SCORE_W = 12;
  localparam int DIST_W  = 17;
  localparam int DEPTH_W = 7;
  localparam int IDX_W   = 10;
  localparam int DIM_W   = 9;

  localparam int W_STRAIGHT = 10;
  localparam int W_DIAG     = 6;
  localparam int ALT_LIMIT  = 25;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [1:0] CFG_MAP_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_LAYER_SELECT = 2'd2;

  localparam logic [2:0] DIR_LAST = 3'd7;

  typedef struct packed {
    logic                      req_type;
    logic [COORD_W-1:0]        cell_x;
    logic [COORD_W-1:0]        cell_y;
    logic                      cell_layer;
    logic                      cell_blocked;
    logic signed [ALT_W-1:0]   cell_altitude;
    logic [COORD_W-1:0]        start_x;
    logic [COORD_W-1:0]        start_y;
    logic [COORD_W-1:0]        target_x;
    logic [COORD_W-1:0]        target_y;
    logic [COORD_W-1:0]        escape_steps;
  } req_t;

  typedef struct packed {
    logic [2:0]          step_dir;
    logic [DEPTH_W-1:0]  path_length;
    logic [COORD_W-1:0]  stop_x;
    logic [COORD_W-1:0]  stop_y;
    logic                empty_path;
    logic                last;
  } res_t;

  typedef struct packed {
    logic                is_open;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [SCORE_W-1:0]  score;
    logic [DEPTH_W-1:0]  depth;
    logic [IDX_W-1:0]    parent;
    logic [2:0]          dir;
  } node_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RUN_INIT, S_SCAN_CHK, S_SCAN, S_PICK, S_BASE_RD, S_BASE,
    S_NB_RD, S_NB_EV, S_BP_RD, S_BP_WR, S_RUN_DONE, S_WIPE, S_OUT_RD, S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  // neighbour table, two's complement step of -1, 0 or +1
  function automatic logic [1:0] dir_dx(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd0, 3'd4:       r = 2'b00;
      3'd1, 3'd2, 3'd3: r = 2'b11;
      default:          r = 2'b01;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dir_dy(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd2, 3'd6:       r = 2'b00;
      3'd3, 3'd4, 3'd5: r = 2'b11;
      default:          r = 2'b01;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/grid_best_first_path_search.sv =====
// Top level: greedy best-first 8-neighbour grid path search with streamed path.
//
//  channel  dir  handshake                payload
//  req      in   req_valid / req_stall    req_word  (req_t)  map write or search
//  res      out  res_valid / res_stall    res_word  (res_t)  one path step
//  cfg      in   cfg_we                   cfg_index, cfg_data
//
// A map write is accepted while idle. A search runs one or two passes; each
// pass expands up to MAX_STEPS nodes, each by a scan of the node RAM for the
// best open node and an evaluation of its neighbours, then a walk of the
// parent chain if a path is found and a wipe of the visited marks it set.
// Each result word is read from the path buffer, loaded and held while
// res_stall is high. After reset the visited RAM is cleared, req_stall high.
`include "grid_best_first_path_search_macros.svh"

module grid_best_first_path_search
  import gbfs_pkg::*;
#(
  parameter int MAX_STEPS    = P_MAX_STEPS,
  parameter int GRID_SIDE    = P_GRID_SIDE,
  parameter int MAX_PATH_OUT = P_MAX_PATH_OUT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req_word,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res_word,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam int NODE_CAP = 8 * MAX_STEPS + 1;
  localparam int NAW      = $clog2(NODE_CAP);
  localparam int CW       = $clog2(GRID_SIDE);
  localparam int VAW      = 2 * CW;
  localparam int VDEPTH   = 1 << VAW;
  localparam int MDEPTH   = 2 * VDEPTH;
  localparam int PAW      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  function automatic logic in_map(input logic [9:0] x, input logic [9:0] y,
                                  input logic [DIM_W-1:0] w,
                                  input logic [DIM_W-1:0] h);
    return !x[9] && (x[8:0] < w) && !y[9] && (y[8:0] < h);
  endfunction

  state_t state, state_next;

  // configuration
  logic [DIM_W-1:0] map_width, map_height;
  logic             layer_select;
  logic [DIM_W-1:0] w_eff, h_eff;

  // request
  logic [COORD_W-1:0] start_x, start_y, goal_x, goal_y;
  logic               flee;
  logic [15:0]        flee_r2;
  logic               run2;

  // search state
  logic [IDX_W-1:0]   node_count, open_count, log_count;
  logic [DEPTH_W-1:0] closed_count, path_count;
  logic [COORD_W-1:0] reached_x, reached_y;
  logic [DIST_W-1:0]  dold;
  logic [IDX_W-1:0]   scan_addr, pend_idx, best_idx, cur_idx, bp_idx, wipe_addr;
  logic               scan_pend, have_best, wipe_pend;
  node_t              best, cur;
  logic signed [ALT_W-1:0] base_alt;
  logic [2:0]         dir;
  logic [9:0]         nb_x, nb_y;
  logic               nb_in;
  logic [SCORE_W-1:0] nb_score;
  logic [DIST_W-1:0]  nb_dist;
  logic [DEPTH_W-1:0] bp_k, out_k, out_n;
  logic [VAW:0]       clr_cnt;

  // memory ports
  logic             map_we, vis_we, vis_wdata, vis_rdata, node_we, log_we, pb_we;
  logic [VAW:0]     map_waddr, map_raddr;
  logic [ALT_W:0]   map_wdata, map_rdata;
  logic [VAW-1:0]   vis_waddr, vis_raddr, log_wdata, log_rdata;
  logic [NAW-1:0]   node_waddr, node_raddr, log_waddr, log_raddr;
  node_t            node_wdata, node_rdata;
  logic [PAW-1:0]   pb_waddr, pb_raddr;
  logic [2:0]       pb_wdata, pb_rdata;

  // metric unit
  logic [COORD_W-1:0] pt_x, pt_y;
  logic [SCORE_W-1:0] met_score;
  logic [DIST_W-1:0]  met_dist;

  // combinational helpers
  logic [1:0]  ddx, ddy;
  logic [9:0]  nx, ny;
  logic        start_in, cur_in, start_eq, better, ok_move, room, found, again;
  logic signed [ALT_W:0] alt_diff;

  gbfs_metric u_metric (
    .goal_x(goal_x), .goal_y(goal_y), .pt_x(pt_x), .pt_y(pt_y),
    .score(met_score), .dist_sq(met_dist)
  );

  gbfs_ram #(.WIDTH(ALT_W+1), .DEPTH(MDEPTH), .AW(VAW+1)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  gbfs_ram #(.WIDTH(1), .DEPTH(VDEPTH), .AW(VAW)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  gbfs_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_CAP), .AW(NAW)) u_nodes (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  // addresses of cells marked visited in the current pass, for the wipe
  gbfs_ram #(.WIDTH(VAW), .DEPTH(NODE_CAP), .AW(NAW)) u_mark_log (
    .clk(clk), .we(log_we), .waddr(log_waddr), .wdata(log_wdata),
    .raddr(log_raddr), .rdata(log_rdata)
  );

  gbfs_ram #(.WIDTH(3), .DEPTH(MAX_STEPS), .AW(PAW)) u_path (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
    .raddr(pb_raddr), .rdata(pb_rdata)
  );

  assign req_stall = (state != S_IDLE);

  always_comb begin
    w_eff = (map_width > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : map_width;
    h_eff = (map_height > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : map_height;
    ddx = dir_dx(dir);
    ddy = dir_dy(dir);
    nx = {2'b00, cur.x} + {{8{ddx[1]}}, ddx};
    ny = {2'b00, cur.y} + {{8{ddy[1]}}, ddy};
    start_in = in_map({2'b00, start_x}, {2'b00, start_y}, w_eff, h_eff);
    cur_in   = in_map({2'b00, cur.x}, {2'b00, cur.y}, w_eff, h_eff);
    start_eq = (start_x == goal_x) && (start_y == goal_y);
    better   = flee ? (node_rdata.score > best.score) : (node_rdata.score < best.score);
    alt_diff = {base_alt[ALT_W-1], base_alt} -
               {map_rdata[ALT_W-1], map_rdata[ALT_W-1:0]};
    ok_move  = nb_in && !vis_rdata && !map_rdata[ALT_W] &&
               (alt_diff <= (ALT_W+1)'(ALT_LIMIT)) && (alt_diff >= -(ALT_W+1)'(ALT_LIMIT));
    room     = node_count < IDX_W'(NODE_CAP);
    found    = ok_move && room &&
               (flee ? ((nb_dist > dold) && (nb_dist >= {1'b0, flee_r2}))
                     : ((nb_x[7:0] == goal_x) && (nb_y[7:0] == goal_y)));
    again    = !run2 && ((path_count == '0) || flee);
    out_n    = (path_count > DEPTH_W'(MAX_PATH_OUT)) ? DEPTH_W'(MAX_PATH_OUT) : path_count;
    pt_x     = (state == S_RUN_INIT) ? start_x : nx[7:0];
    pt_y     = (state == S_RUN_INIT) ? start_y : ny[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    map_we     = 1'b0;
    map_waddr  = {req_word.cell_layer, req_word.cell_y[CW-1:0], req_word.cell_x[CW-1:0]};
    map_wdata  = {req_word.cell_blocked, req_word.cell_altitude};
    map_raddr  = {layer_select, cur.y[CW-1:0], cur.x[CW-1:0]};
    vis_we     = 1'b0;
    vis_waddr  = {nb_y[CW-1:0], nb_x[CW-1:0]};
    vis_wdata  = 1'b1;
    vis_raddr  = {ny[CW-1:0], nx[CW-1:0]};
    node_we    = 1'b0;
    node_waddr = node_count[NAW-1:0];
    node_wdata = '{is_open: 1'b1, x: nb_x[7:0], y: nb_y[7:0], score: nb_score,
                   depth: cur.depth + 1'b1, parent: cur_idx, dir: dir};
    node_raddr = scan_addr[NAW-1:0];
    log_we     = 1'b0;
    log_waddr  = log_count[NAW-1:0];
    log_wdata  = {nb_y[CW-1:0], nb_x[CW-1:0]};
    log_raddr  = wipe_addr[NAW-1:0];
    pb_we      = 1'b0;
    pb_waddr   = cur.depth[PAW-1:0];
    pb_wdata   = dir;
    pb_raddr   = out_k[PAW-1:0];
    unique case (state)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_cnt[VAW-1:0];
        vis_wdata = 1'b0;
        if (clr_cnt == (VAW+1)'(VDEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req_word.req_type == REQ_WRITE) begin
            map_we = ({1'b0, req_word.cell_x} < DIM_W'(GRID_SIDE)) &&
                     ({1'b0, req_word.cell_y} < DIM_W'(GRID_SIDE));
          end else begin
            state_next = S_RUN_INIT;
          end
        end
      end
      S_RUN_INIT: begin
        if (start_eq) begin
          state_next = S_RUN_DONE;
        end else begin
          node_we    = 1'b1;
          node_waddr = '0;
          node_wdata = '{is_open: 1'b1, x: start_x, y: start_y, score: met_score,
                         depth: '0, parent: '0, dir: 3'd0};
          if (start_in) begin
            vis_we    = 1'b1;
            vis_waddr = {start_y[CW-1:0], start_x[CW-1:0]};
            log_we    = 1'b1;
            log_waddr = '0;
            log_wdata = {start_y[CW-1:0], start_x[CW-1:0]};
          end
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if ((closed_count >= DEPTH_W'(MAX_STEPS)) || (open_count == '0)) begin
          state_next = S_RUN_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if ((scan_addr == node_count) && !scan_pend) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        node_we    = 1'b1;
        node_waddr = best_idx[NAW-1:0];
        node_wdata = best;
        node_wdata.is_open = 1'b0;
        if (best.depth >= DEPTH_W'(MAX_STEPS)) begin
          state_next = S_SCAN_CHK;
        end else begin
          state_next = S_BASE_RD;
        end
      end
      S_BASE_RD: state_next = S_BASE;
      S_BASE:    state_next = S_NB_RD;
      S_NB_RD: begin
        map_raddr  = {layer_select, ny[CW-1:0], nx[CW-1:0]};
        state_next = S_NB_EV;
      end
      S_NB_EV: begin
        if (ok_move) begin
          vis_we  = 1'b1;
          log_we  = 1'b1;
          node_we = room;
        end
        pb_we = found;
        if (found) begin
          state_next = S_BP_RD;
        end else if (dir == DIR_LAST) begin
          state_next = S_SCAN_CHK;
        end else begin
          state_next = S_NB_RD;
        end
      end
      S_BP_RD: begin
        node_raddr = bp_idx[NAW-1:0];
        if ((bp_idx != '0) && (bp_k != '0)) begin
          state_next = S_BP_WR;
        end else begin
          state_next = S_RUN_DONE;
        end
      end
      S_BP_WR: begin
        pb_we      = 1'b1;
        pb_waddr   = PAW'(bp_k - 1'b1);
        pb_wdata   = node_rdata.dir;
        state_next = S_BP_RD;
      end
      S_RUN_DONE: state_next = S_WIPE;
      S_WIPE: begin
        if (wipe_pend) begin
          vis_we    = 1'b1;
          vis_waddr = log_rdata;
          vis_wdata = 1'b0;
        end
        if ((wipe_addr == log_count) && !wipe_pend) begin
          state_next = again ? S_RUN_INIT : S_OUT_RD;
        end
      end
      S_OUT_RD: state_next = S_OUT_LD;
      S_OUT_LD: state_next = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (!res_stall) begin
          state_next = res_word.last ? S_IDLE : S_OUT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width    <= DIM_W'(256);
      map_height   <= DIM_W'(256);
      layer_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:    map_width    <= cfg_data;
        CFG_MAP_HEIGHT:   map_height   <= cfg_data;
        CFG_LAYER_SELECT: layer_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      node_count   <= '0;
      open_count   <= '0;
      closed_count <= '0;
      log_count    <= '0;
      path_count   <= '0;
      reached_x    <= '0;
      reached_y    <= '0;
      res_valid    <= 1'b0;
      scan_pend    <= 1'b0;
      wipe_pend    <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        S_IDLE: begin
          if (req_valid && (req_word.req_type == REQ_SEARCH)) begin
            start_x <= req_word.start_x;
            start_y <= req_word.start_y;
            goal_x  <= req_word.target_x;
            goal_y  <= req_word.target_y;
            flee    <= (req_word.escape_steps != '0);
            flee_r2 <= req_word.escape_steps * req_word.escape_steps;
            run2    <= 1'b0;
          end
        end
        S_RUN_INIT: begin
          reached_x  <= start_x;
          reached_y  <= start_y;
          path_count <= '0;
          if (!start_eq) begin
            dold         <= met_dist;
            node_count   <= IDX_W'(1);
            open_count   <= IDX_W'(1);
            closed_count <= '0;
            log_count    <= IDX_W'(start_in);
          end
        end
        S_SCAN_CHK: begin
          scan_addr <= '0;
          scan_pend <= 1'b0;
          have_best <= 1'b0;
        end
        S_SCAN: begin
          if (scan_addr < node_count) begin
            scan_addr <= scan_addr + 1'b1;
            pend_idx  <= scan_addr;
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
          end
          if (scan_pend && node_rdata.is_open && (!have_best || better)) begin
            best      <= node_rdata;
            best_idx  <= pend_idx;
            have_best <= 1'b1;
          end
        end
        S_PICK: begin
          open_count   <= open_count - 1'b1;
          closed_count <= closed_count + 1'b1;
          cur          <= best;
          cur_idx      <= best_idx;
        end
        S_BASE: begin
          base_alt <= cur_in ? $signed(map_rdata[ALT_W-1:0]) : '0;
          dir      <= '0;
        end
        S_NB_RD: begin
          nb_x     <= nx;
          nb_y     <= ny;
          nb_in    <= in_map(nx, ny, w_eff, h_eff);
          nb_score <= met_score;
          nb_dist  <= met_dist;
        end
        S_NB_EV: begin
          if (ok_move) begin
            log_count <= log_count + 1'b1;
            if (room) begin
              node_count <= node_count + 1'b1;
              open_count <= open_count + 1'b1;
              // approach keeps the closest point, escape the farthest
              if (flee ? (nb_dist > dold) : (nb_dist < dold)) begin
                reached_x <= nb_x[7:0];
                reached_y <= nb_y[7:0];
                dold      <= nb_dist;
              end
            end
          end
          if (found) begin
            path_count <= cur.depth + 1'b1;
            bp_k       <= cur.depth;
            bp_idx     <= cur_idx;
          end
          dir <= dir + 1'b1;
        end
        S_BP_WR: begin
          bp_idx <= node_rdata.parent;
          bp_k   <= bp_k - 1'b1;
        end
        S_RUN_DONE: begin
          wipe_addr <= '0;
          wipe_pend <= 1'b0;
        end
        S_WIPE: begin
          if (wipe_addr < log_count) begin
            wipe_addr <= wipe_addr + 1'b1;
            wipe_pend <= 1'b1;
          end else begin
            wipe_pend <= 1'b0;
          end
          if ((wipe_addr == log_count) && !wipe_pend) begin
            log_count <= '0;
            out_k     <= '0;
            if (again) begin
              // second pass heads for the point the first one reached
              run2   <= 1'b1;
              goal_x <= reached_x;
              goal_y <= reached_y;
              flee   <= 1'b0;
            end
          end
        end
        S_OUT_LD: begin
          res_word.step_dir    <= (out_n == '0) ? 3'd0 : pb_rdata;
          res_word.path_length <= out_n;
          res_word.stop_x      <= reached_x;
          res_word.stop_y      <= reached_y;
          res_word.empty_path  <= (out_n == '0);
          res_word.last        <= (out_n == '0) || (out_k == out_n - 1'b1);
          res_valid            <= 1'b1;
        end
        S_OUT_WAIT: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            out_k     <= out_k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `GBFS_CHECK(a_res_only_in_wait, !res_valid || (state == S_OUT_WAIT), "result word outside output")
  `GBFS_CHECK(a_node_cap, (node_count <= IDX_W'(NODE_CAP)) && (open_count <= node_count), "node count")
  `GBFS_CHECK(a_closed_limit, closed_count <= DEPTH_W'(MAX_STEPS), "expansion count beyond limit")
  `GBFS_CHECK_NEXT(a_last_to_idle, res_valid && !res_stall && res_word.last, state == S_IDLE, "no idle")

endmodule

// ===== hdl/gbfs_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module gbfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gbfs_metric.sv =====
// Shared distance unit: octile score and squared distance to the goal.
module gbfs_metric
  import gbfs_pkg::*;
(
  input  logic [COORD_W-1:0] goal_x,
  input  logic [COORD_W-1:0] goal_y,
  input  logic [COORD_W-1:0] pt_x,
  input  logic [COORD_W-1:0] pt_y,
  output logic [SCORE_W-1:0] score,
  output logic [DIST_W-1:0]  dist_sq
);

  logic [COORD_W-1:0] dx, dy, dmax, dmin;
  logic [2*COORD_W-1:0] dx2, dy2;

  always_comb begin
    dx   = (goal_x > pt_x) ? goal_x - pt_x : pt_x - goal_x;
    dy   = (goal_y > pt_y) ? goal_y - pt_y : pt_y - goal_y;
    dmax = (dx > dy) ? dx : dy;
    dmin = (dx > dy) ? dy : dx;
    score = SCORE_W'(W_STRAIGHT) * SCORE_W'(dmax) + SCORE_W'(W_DIAG) * SCORE_W'(dmin);
    dx2  = dx * dx;
    dy2  = dy * dy;
    dist_sq = DIST_W'(dx2) + DIST_W'(dy2);
  end

endmodule

// ===== bench/path_checker.sv =====
// Watches the request, result and config ports, predicts the path words and compares them.
module path_checker
  import gbfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  req_t             req_word,
  input  logic             res_valid,
  input  logic             res_stall,
  input  res_t             res_word,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int SIDE  = P_GRID_SIDE;
  localparam int NODES = P_MAX_STEPS * 8 + 1;

  int step_x [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
  int step_y [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

  logic [16:0] map_mem [0:2*SIDE*SIDE-1];
  bit seen [SIDE*SIDE];
  int seen_list [$];

  int node_x [NODES];
  int node_y [NODES];
  int node_score [NODES];
  int node_depth [NODES];
  int node_up [NODES];
  int node_dir [NODES];
  int open_q [NODES];
  int open_n, node_n, closed_n;

  int near_x, near_y, goal_x, goal_y;
  bit fleeing;
  int flee_r;
  int route [P_MAX_STEPS];
  int route_n;

  int width_reg  = 256;
  int height_reg = 256;
  int layer_reg  = 0;

  res_t want_q [$];
  int fails = 0;

  function automatic int clamp_dim(int v);
    return v > SIDE ? SIDE : v;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < clamp_dim(width_reg) && y < clamp_dim(height_reg);
  endfunction

  function automatic logic [16:0] cell_at(int x, int y);
    return map_mem[layer_reg * SIDE * SIDE + y * SIDE + x];
  endfunction

  function automatic int alt_at(int x, int y);
    logic [16:0] w;
    w = cell_at(x, y);
    return int'($signed(w[15:0]));
  endfunction

  // octile distance to the current goal, 10 times the larger axis distance plus 6 times the smaller
  function automatic int octile(int x, int y);
    int ax, ay;
    ax = goal_x > x ? goal_x - x : x - goal_x;
    ay = goal_y > y ? goal_y - y : y - goal_y;
    return ax > ay ? 10 * ax + 6 * ay : 10 * ay + 6 * ax;
  endfunction

  function automatic int sq_dist(int x, int y);
    int ax, ay;
    ax = goal_x - x;
    ay = goal_y - y;
    return ax * ax + ay * ay;
  endfunction

  function automatic void trace_route(int idx);
    int n, k;
    n = node_depth[idx];
    if (n > P_MAX_STEPS) n = P_MAX_STEPS;
    k = n;
    while (idx != 0 && idx < NODES && k > 0) begin
      k--;
      route[k] = node_dir[idx];
      idx = node_up[idx];
    end
    route_n = n;
  endfunction

  // open the legal neighbours of one node; 1 when a route has been found
  function automatic bit grow(int idx);
    int base, nx, ny, c, dn, dold, diff, ni;
    logic [16:0] w;
    base = on_grid(node_x[idx], node_y[idx]) ? alt_at(node_x[idx], node_y[idx]) : 0;
    for (int i = 0; i < 8; i++) begin
      nx = node_x[idx] + step_x[i];
      ny = node_y[idx] + step_y[i];
      if (!on_grid(nx, ny)) continue;
      c = ny * SIDE + nx;
      if (seen[c]) continue;
      w = cell_at(nx, ny);
      if (w[16]) continue;
      diff = base - alt_at(nx, ny);
      if (diff > ALT_LIMIT || diff < -ALT_LIMIT) continue;
      seen[c] = 1;
      seen_list.insert(seen_list.size(), c);
      if (node_n >= NODES) continue;
      ni = node_n++;
      node_x[ni]     = nx;
      node_y[ni]     = ny;
      node_score[ni] = octile(nx, ny);
      node_depth[ni] = node_depth[idx] + 1;
      node_up[ni]    = idx;
      node_dir[ni]   = i;
      open_q[open_n++] = ni;
      dn   = sq_dist(nx, ny);
      dold = sq_dist(near_x, near_y);
      if (!fleeing) begin
        if (dn < dold) begin
          near_x = nx;
          near_y = ny;
        end
        if (nx == goal_x && ny == goal_y) begin
          trace_route(ni);
          return 1;
        end
      end else if (dn > dold) begin
        near_x = nx;
        near_y = ny;
        if (dn >= flee_r * flee_r) begin
          trace_route(ni);
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic void best_first(int sx, int sy, int tx, int ty, bit fl);
    int best, pick;
    fleeing = fl;
    near_x  = sx;
    near_y  = sy;
    goal_x  = tx;
    goal_y  = ty;
    route_n = 0;
    if (sx == tx && sy == ty) return;
    foreach (seen_list[k]) seen[seen_list[k]] = 0;
    seen_list.delete();
    closed_n      = 0;
    node_x[0]     = sx;
    node_y[0]     = sy;
    node_score[0] = octile(sx, sy);
    node_depth[0] = 0;
    node_up[0]    = 0;
    node_dir[0]   = 0;
    node_n        = 1;
    open_q[0]     = 0;
    open_n        = 1;
    if (on_grid(sx, sy)) begin
      seen[sy * SIDE + sx] = 1;
      seen_list.insert(seen_list.size(), sy * SIDE + sx);
    end
    while (1) begin
      if (closed_n >= P_MAX_STEPS || open_n == 0) return;
      best = 0;
      for (int i = 1; i < open_n; i++) begin
        if (fl ? (node_score[open_q[i]] > node_score[open_q[best]])
               : (node_score[open_q[i]] < node_score[open_q[best]]))
          best = i;
      end
      pick = open_q[best];
      for (int i = best; i + 1 < open_n; i++) open_q[i] = open_q[i + 1];
      open_n--;
      closed_n++;
      if (node_depth[pick] >= P_MAX_STEPS) continue;
      if (grow(pick)) return;
    end
  endfunction

  // a search request: escape pass or failed approach is followed by an approach
  // toward the point reached
  function automatic void plan(req_t r);
    int sx, sy, n, rx, ry;
    bit fl;
    res_t w;
    sx = int'(r.start_x);
    sy = int'(r.start_y);
    flee_r = int'(r.escape_steps);
    fl = flee_r != 0;
    best_first(sx, sy, int'(r.target_x), int'(r.target_y), fl);
    if (route_n == 0 || fl) begin
      rx = near_x;
      ry = near_y;
      best_first(sx, sy, rx, ry, 1'b0);
    end
    n = route_n > P_MAX_PATH_OUT ? P_MAX_PATH_OUT : route_n;
    w.stop_x = near_x[7:0];
    w.stop_y = near_y[7:0];
    if (n == 0) begin
      w.step_dir    = '0;
      w.path_length = '0;
      w.empty_path  = 1'b1;
      w.last        = 1'b1;
      want_q.insert(want_q.size(), w);
    end else begin
      for (int k = 0; k < n; k++) begin
        w.step_dir    = route[k][2:0];
        w.path_length = n[DEPTH_W-1:0];
        w.empty_path  = 1'b0;
        w.last        = (k + 1 == n);
        want_q.insert(want_q.size(), w);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    res_t w;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAP_WIDTH:    width_reg  = int'(cfg_data);
          CFG_MAP_HEIGHT:   height_reg = int'(cfg_data);
          CFG_LAYER_SELECT: layer_reg  = int'(cfg_data[0]);
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        if (req_word.req_type == REQ_WRITE)
          map_mem[req_word.cell_layer * SIDE * SIDE + req_word.cell_y * SIDE
                  + req_word.cell_x] = {req_word.cell_blocked, req_word.cell_altitude};
        else
          plan(req_word);
      end
      if (res_valid && !res_stall) begin
        if (want_q.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          w = want_q.pop_front();
          // step code carries nothing on an empty path
          if (!w.empty_path && res_word.step_dir !== w.step_dir) begin
            $error("step_dir expected %0d got %0d", w.step_dir, res_word.step_dir);
            fails++;
          end
          if (res_word.path_length !== w.path_length) begin
            $error("path_length expected %0d got %0d", w.path_length, res_word.path_length);
            fails++;
          end
          if (res_word.stop_x !== w.stop_x) begin
            $error("stop_x expected %0d got %0d", w.stop_x, res_word.stop_x);
            fails++;
          end
          if (res_word.stop_y !== w.stop_y) begin
            $error("stop_y expected %0d got %0d", w.stop_y, res_word.stop_y);
            fails++;
          end
          if (res_word.empty_path !== w.empty_path) begin
            $error("empty_path expected %0d got %0d", w.empty_path, res_word.empty_path);
            fails++;
          end
          if (res_word.last !== w.last) begin
            $error("last expected %0d got %0d", w.last, res_word.last);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= want_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the grid search bench: clock, reset, map and search stimulus, verdict.
module tb_top;
  import gbfs_pkg::*;

  localparam int AREA        = 5;       // fully written patch at the origin
  localparam int CORNER      = 252;     // fully written patch at the far corner
  localparam int QUIET       = 100;     // cycles let pass once nothing is expected
  localparam int STALL_LIMIT = 400000;  // covers clear pass, two full passes, long hold
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASE_ITEMS = 10;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req_word = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_t             res_word;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  int fail_count, pending;
  int burst_left = 0;
  int idle_cnt = 0;
  bit long_hold = 0;
  bit hold_done = 0;

  grid_best_first_path_search dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  path_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_word   (req_word),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_word   (res_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // random fill so unused fields of every word toggle too
  function automatic req_t noise_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic req_t write_word(int x, int y, int layer, int blk, int alt);
    req_t w;
    w = noise_word();
    w.req_type      = REQ_WRITE;
    w.cell_x        = x[COORD_W-1:0];
    w.cell_y        = y[COORD_W-1:0];
    w.cell_layer    = layer[0];
    w.cell_blocked  = blk[0];
    w.cell_altitude = alt[ALT_W-1:0];
    return w;
  endfunction

  function automatic req_t search_word(int sx, int sy, int tx, int ty, int esc);
    req_t w;
    w = noise_word();
    w.req_type     = REQ_SEARCH;
    w.start_x      = sx[COORD_W-1:0];
    w.start_y      = sy[COORD_W-1:0];
    w.target_x     = tx[COORD_W-1:0];
    w.target_y     = ty[COORD_W-1:0];
    w.escape_steps = esc[COORD_W-1:0];
    return w;
  endfunction

  // valid stays up inside a burst; a gap follows the last word of each burst
  task automatic send(input req_t w);
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall !== 1'b0);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 60 : 8)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // drop valid and wait for every expected word plus tail latency
  task automatic settle();
    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[DIM_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_map(input int wd, input int ht, input int layer);
    cfg_write(CFG_MAP_WIDTH, wd);
    cfg_write(CFG_MAP_HEIGHT, ht);
    cfg_write(CFG_LAYER_SELECT, layer);
  endtask

  // small altitude steps keep most moves legal; a few cliffs and blocks
  task automatic paint(input int x, input int y, input int layer, input bit edge_wall);
    int alt, blk;
    alt = ($urandom_range(0, 19) == 0) ? int'($urandom) : $urandom_range(0, 16) - 8;
    blk = edge_wall ? 1 : int'($urandom_range(0, 6) == 0);
    send(write_word(x, y, layer, blk, alt));
  endtask

  function automatic int pick_coord(int span);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
  endfunction

  task automatic random_search(input int span);
    int esc;
    case ($urandom_range(0, 9))
      0:       esc = $urandom_range(0, 255);
      1, 2, 3: esc = $urandom_range(1, 6);
      default: esc = 0;
    endcase
    send(search_word(pick_coord(span), pick_coord(span), pick_coord(span),
                     pick_coord(span), esc));
  endtask

  // receiver: stretches of no stall, light stall and heavy stall, one long hold
  initial begin
    int len, mode;
    forever begin
      len  = $urandom_range(1, 40);
      mode = $urandom_range(0, 2);
      repeat (len) begin
        @(posedge clk);
        if (long_hold && !hold_done) begin
          res_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1;
        end
        case (mode)
          0:       res_stall <= 1'b0;
          1:       res_stall <= 1'($urandom_range(0, 1));
          default: res_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // no word moving on either side for too long means a hang
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cnt <= 0;
    end else if (idle_cnt == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int span;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // origin patch on both layers, then the corner island walled off on
    // its inner row and column so no search from inside reads further
    set_map(AREA, AREA, 0);
    for (int l = 0; l < 2; l++)
      for (int y = 0; y < AREA; y++)
        for (int x = 0; x < AREA; x++)
          paint(x, y, l, 1'b0);
    for (int l = 0; l < 2; l++)
      for (int y = CORNER; y < 256; y++)
        for (int x = CORNER; x < 256; x++)
          paint(x, y, l, x == CORNER || y == CORNER);
    send(write_word(0, 0, 0, 0, 0));
    send(write_word(1, 1, 0, 0, 25));
    send(write_word(2, 2, 0, 0, -1));

    // directed: start on target, corner to corner, escapes, start off the map
    send(search_word(5, 5, 5, 5, 0));
    send(search_word(0, 0, AREA - 1, AREA - 1, 0));
    send(search_word(AREA - 1, 0, 0, AREA - 1, 0));
    send(search_word(2, 2, 2, 2, 3));
    send(search_word(0, 0, 0, 0, 255));
    send(search_word(3, 3, 9, 2, 1));
    send(search_word(200, 100, 3, 3, 0));
    send(search_word(AREA, 2, 0, 2, 0));
    settle();

    // full-size and oversized map, searches kept inside the corner island
    set_map(256, 256, 0);
    send(search_word(254, 254, 255, 255, 0));
    send(search_word(255, 255, 0, 0, 0));
    send(search_word(253, 253, 255, 255, 2));
    settle();
    set_map(511, 511, 1);
    send(search_word(255, 253, 253, 255, 0));
    send(search_word(254, 255, 254, 255, 4));
    settle();

    // degenerate maps: nothing is inside, or only the start
    set_map(0, 0, 0);
    send(search_word(3, 3, 5, 5, 0));
    send(search_word(3, 3, 5, 5, 2));
    settle();
    set_map(1, 1, 1);
    cfg_write(CFG_SPARE, $urandom_range(0, 511));
    send(search_word(0, 0, 0, 5, 0));
    send(search_word(0, 0, 0, 5, 1));
    settle();

    set_map(AREA, AREA, 1);
    send(search_word(0, 0, AREA - 1, AREA - 1, 0));
    send(search_word(AREA - 1, AREA - 1, 0, 0, 5));
    settle();

    // random phases, each on its own map setting; mostly searches on the
    // written patch with cell rewrites mixed in
    for (int ph = 0; ph < 4; ph++) begin
      span = (ph == 0) ? AREA : $urandom_range(1, AREA);
      set_map(span, (ph == 1) ? AREA : $urandom_range(1, AREA), $urandom_range(0, 1));
      if (ph == 2) long_hold = 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 3) == 0)
            send(write_word($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 1), $urandom_range(0, 1), int'($urandom)));
          else
            paint($urandom_range(0, AREA - 1), $urandom_range(0, AREA - 1),
                  $urandom_range(0, 1), 1'b0);
        end else begin
          random_search(span);
        end
        // sender pauses until the block has drained
        if (i == PHASE_ITEMS / 2) settle();
      end
      settle();
    end

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gbfs_pkg.sv
hdl/gbfs_ram.sv
hdl/gbfs_metric.sv
hdl/grid_best_first_path_search.sv
bench/path_checker.sv
bench/tb_top.sv
